FILE: rtl/core/bfgr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfgr_pkg
// Beat types, field widths and the 8x8 font ROM of the glyph rasterizer.
// ----------------------------------------------------------------------------
package bfgr_pkg;

  localparam int CODE_W   = 7;
  localparam int ORGX_W   = 10;
  localparam int ORGY_W   = 11;
  localparam int CHAN_W   = 8;
  localparam int ADDR_W   = 21;
  localparam int VALUE_W  = 24;
  localparam int GLYPH_W  = 64;
  localparam int PIX_W    = 6;
  localparam int ROW_W    = ORGY_W + 1;
  localparam int COL_W    = ORGX_W + 1;
  localparam int ORGX_MAX = (1 << ORGX_W) - 1;
  localparam int ORGY_MAX = (1 << ORGY_W) - 1;
  localparam int GLYPH_SIDE_MAX = 7;
  localparam logic [PIX_W-1:0] LAST_PIX = PIX_W'(GLYPH_W - 1);

  typedef struct packed {
    logic [CODE_W-1:0] char_code;
    logic [ORGX_W-1:0] origin_x;
    logic [ORGY_W-1:0] origin_y;
    logic [CHAN_W-1:0] fg_red;
    logic [CHAN_W-1:0] fg_green;
    logic [CHAN_W-1:0] fg_blue;
    logic [CHAN_W-1:0] bg_red;
    logic [CHAN_W-1:0] bg_green;
    logic [CHAN_W-1:0] bg_blue;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  pixel_address;
    logic [VALUE_W-1:0] pixel_rgb;
    logic               is_foreground;
    logic               last_pixel;
  } pixel_t;

  function automatic logic [VALUE_W-1:0] pack_colour(
    input logic [CHAN_W-1:0] r,
    input logic [CHAN_W-1:0] g,
    input logic [CHAN_W-1:0] b
  );
    return {r[3:0], 4'h0, g[3:0], 4'h0, b[3:0], 4'h0};
  endfunction

  function automatic logic [GLYPH_W-1:0] glyph_bits(input logic [CODE_W-1:0] code);
    logic [GLYPH_W-1:0] g;
    unique case (code)
      7'h61:   g = 64'h3078ccccfccccc00;
      7'h62:   g = 64'hfc66667c6666fc00;
      7'h63:   g = 64'h3c66c0c0c0663c00;
      7'h64:   g = 64'hf86c6666666cf800;
      7'h65:   g = 64'hfe6268786862fe00;
      7'h66:   g = 64'hfe6268786860f000;
      7'h67:   g = 64'h3c66c0c0ce663e00;
      7'h68:   g = 64'hccccccfccccccc00;
      7'h69:   g = 64'h7830303030307800;
      7'h6a:   g = 64'h1e0c0c0ccccc7800;
      7'h6b:   g = 64'he6666c786c66e600;
      7'h6c:   g = 64'hf06060606266fe00;
      7'h6d:   g = 64'hc6eefefed6666600;
      7'h6e:   g = 64'hc6e6f6decec6c600;
      7'h6f:   g = 64'h386cc6c6c66c3800;
      7'h70:   g = 64'hfc66667c6060f000;
      7'h71:   g = 64'h78ccccccdc7c1c00;
      7'h72:   g = 64'hfc66667c6c66e600;
      7'h73:   g = 64'h78cce0701ccc7800;
      7'h74:   g = 64'hfcb4303030307800;
      7'h75:   g = 64'hccccccccccccfc00;
      7'h76:   g = 64'hcccccccccc783000;
      7'h77:   g = 64'hc6c6c6d6feeec600;
      7'h78:   g = 64'hc6c66c38386cc600;
      7'h79:   g = 64'hcccccc7830307800;
      7'h7a:   g = 64'hfec68c183266fe00;
      7'h30:   g = 64'h7cc6cedef6e67c00;
      7'h31:   g = 64'h307030303030fc00;
      7'h32:   g = 64'h78cc0c3860ccfc00;
      7'h33:   g = 64'h78cc0c380ccc7800;
      7'h34:   g = 64'h1c3c6cccfe0c1e00;
      7'h35:   g = 64'hfcc0f80c0ccc7800;
      7'h36:   g = 64'h3860c0fccccc7100;
      7'h37:   g = 64'hfccc0c1830303000;
      7'h38:   g = 64'h78cccc78cccc7800;
      7'h39:   g = 64'h78cccc7c0c187000;
      7'h28:   g = 64'h1830606060301800;
      7'h29:   g = 64'h6030181818306000;
      7'h25:   g = 64'h00c6cc183066c600;
      7'h5f:   g = 64'h00000000000000ff;
      7'h2d:   g = 64'h000000fc00000000;
      7'h2e:   g = 64'h0000000000c0c000;
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bitmap_font_glyph_rasterizer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_font_glyph_rasterizer_core
// Expands one character beat into 64 framebuffer write beats.
// Path: item hold and pixel counter, stages 1 to 3, then the wrap stages lead to
//   the first write beat; WRAP_STEPS follows from ROW_STRIDE and BUFFER_WORDS.
// Throughput: one write beat per cycle, set by the pixel counter; busy drops
//   while the counter is on the last pixel so characters run back to back.
// Reset: synchronous, clears the counter and all stage valid bits.
// ----------------------------------------------------------------------------
module bitmap_font_glyph_rasterizer_core
  import bfgr_pkg::*;
#(
  parameter int ROW_STRIDE   = 1024,
  parameter int BUFFER_WORDS = 2097152
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   start,
  output logic        busy,
  input  wire item_t  item,
  output logic        strobe,
  output pixel_t      pixel
);

  localparam int SUM_MAX    = (ORGY_MAX + GLYPH_SIDE_MAX) * ROW_STRIDE
                              + ORGX_MAX + GLYPH_SIDE_MAX;
  localparam int SUM_W      = $clog2(SUM_MAX + 1);
  localparam int QUO_MAX    = SUM_MAX / BUFFER_WORDS;
  localparam int QUO_W      = $clog2(QUO_MAX + 1);
  localparam int WRAP_STEPS = (QUO_W < 1) ? 1 : QUO_W;

  // item hold and pixel counter
  logic               active;
  logic [PIX_W-1:0]   cnt;
  logic [GLYPH_W-1:0] glyph;
  logic [ORGX_W-1:0]  org_x;
  logic [ORGY_W-1:0]  org_y;
  logic [VALUE_W-1:0] fg_val;
  logic [VALUE_W-1:0] bg_val;
  logic               take;

  assign busy = active && (cnt != LAST_PIX);
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (take) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (active) begin
      if (cnt == LAST_PIX) begin
        active <= 1'b0;
      end else begin
        cnt <= cnt + PIX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      glyph  <= glyph_bits(item.char_code);
      org_x  <= item.origin_x;
      org_y  <= item.origin_y;
      fg_val <= pack_colour(item.fg_red, item.fg_green, item.fg_blue);
      bg_val <= pack_colour(item.bg_red, item.bg_green, item.bg_blue);
    end
  end

  // stage 1: glyph bit, colour, row and column sums
  logic               v1;
  logic [ROW_W-1:0]   row1;
  logic [COL_W-1:0]   col1;
  logic [VALUE_W-1:0] val1;
  logic               fg1;
  logic               last1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= active;
    end
  end

  always_ff @(posedge clk) begin
    row1  <= ROW_W'(org_y) + ROW_W'(cnt[5:3]);
    col1  <= COL_W'(org_x) + COL_W'(cnt[2:0]);
    fg1   <= glyph[~cnt];
    val1  <= glyph[~cnt] ? fg_val : bg_val;
    last1 <= (cnt == LAST_PIX);
  end

  // stage 2: row times stride
  logic               v2;
  logic [SUM_W-1:0]   prod2;
  logic [COL_W-1:0]   col2;
  logic [VALUE_W-1:0] val2;
  logic               fg2;
  logic               last2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    prod2 <= SUM_W'(64'(row1) * 64'(ROW_STRIDE));
    col2  <= col1;
    val2  <= val1;
    fg2   <= fg1;
    last2 <= last1;
  end

  // stage 3 and wrap stages: add column, then subtract buffer multiples
  logic               vw    [WRAP_STEPS+1];
  logic [SUM_W-1:0]   remw  [WRAP_STEPS+1];
  logic [VALUE_W-1:0] valw  [WRAP_STEPS+1];
  logic               fgw   [WRAP_STEPS+1];
  logic               lastw [WRAP_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vw[0] <= 1'b0;
    end else begin
      vw[0] <= v2;
    end
  end

  always_ff @(posedge clk) begin
    remw[0]  <= prod2 + SUM_W'(col2);
    valw[0]  <= val2;
    fgw[0]   <= fg2;
    lastw[0] <= last2;
  end

  for (genvar j = 0; j < WRAP_STEPS; j++) begin : g_wrap
    localparam longint unsigned SUB = longint'(BUFFER_WORDS) << (WRAP_STEPS - 1 - j);

    always_ff @(posedge clk) begin
      if (rst) begin
        vw[j+1] <= 1'b0;
      end else begin
        vw[j+1] <= vw[j];
      end
    end

    always_ff @(posedge clk) begin
      if (64'(remw[j]) >= SUB) begin
        remw[j+1] <= remw[j] - SUM_W'(SUB);
      end else begin
        remw[j+1] <= remw[j];
      end
      valw[j+1]  <= valw[j];
      fgw[j+1]   <= fgw[j];
      lastw[j+1] <= lastw[j];
    end
  end

  assign strobe              = vw[WRAP_STEPS];
  assign pixel.pixel_address = ADDR_W'(64'(remw[WRAP_STEPS]));
  assign pixel.pixel_rgb     = valw[WRAP_STEPS];
  assign pixel.is_foreground = fgw[WRAP_STEPS];
  assign pixel.last_pixel    = lastw[WRAP_STEPS];

endmodule
`default_nettype wire

FILE: rtl/core/bfgr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bfgr_checker
// Port-level checks of the glyph rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module bfgr_checker
  import bfgr_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  input wire logic   start,
  input wire logic   busy,
  input wire logic   strobe,
  input wire pixel_t pixel
);

  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low after a character beat was accepted");

  a_glyph_contiguous : assert property (@(posedge clk) disable iff (rst)
    (strobe && !pixel.last_pixel) |=> strobe)
    else $error("gap inside the write beats of one glyph");

  a_last_not_twice : assert property (@(posedge clk) disable iff (rst)
    (strobe && pixel.last_pixel) |=> !(strobe && pixel.last_pixel))
    else $error("last write beat repeated");

  a_value_pad_zero : assert property (@(posedge clk) disable iff (rst)
    strobe |-> (pixel.pixel_rgb[3:0] == 4'h0) && (pixel.pixel_rgb[11:8] == 4'h0)
               && (pixel.pixel_rgb[19:16] == 4'h0))
    else $error("pixel value has bits set outside the colour nibbles");

endmodule

bind bitmap_font_glyph_rasterizer_core bfgr_checker u_bfgr_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .pixel  (pixel)
);
`default_nettype wire

FILE: test/tb_bitmap_font_glyph_rasterizer_core.sv
// ----------------------------------------------------------------------------
// tb_bitmap_font_glyph_rasterizer_core
// Sends character beats to the glyph rasterizer. A local font table predicts
// the 64 framebuffer write beats of each character: the address, the colour,
// the foreground flag and the last flag. Each write beat is checked field by
// field against the oldest prediction. Directed characters cover a sample of the font,
// blank codes, colour nibbles and address wrap. Random characters follow,
// first with gaps between them and then back to back.
// ----------------------------------------------------------------------------
module tb_bitmap_font_glyph_rasterizer_core;
  import bfgr_pkg::*;

  localparam int ROW_STRIDE   = 1024;
  localparam int BUFFER_WORDS = 2097152;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 16;
  localparam string FONT_CHARS = "abcdefghijklmnopqrstuvwxyz0123456789()%_-.";

  logic   clk   = 1'b0;
  logic   rst   = 1'b1;
  logic   start = 1'b0;
  item_t  item  = '0;
  logic   busy;
  logic   strobe;
  pixel_t pixel;

  pixel_t expected_pixels[$];
  pixel_t want;
  bit     gaps_on = 1'b1;
  int     mismatches = 0;
  int     chars_sent = 0;
  int     blank_chars = 0;
  int     pixels_checked = 0;
  int     idle_cycles = 0;

  bitmap_font_glyph_rasterizer_core #(
    .ROW_STRIDE  (ROW_STRIDE),
    .BUFFER_WORDS(BUFFER_WORDS)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .item  (item),
    .strobe(strobe),
    .pixel (pixel)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] glyph_for(input logic [CODE_W-1:0] code);
    case ({1'b0, code})
      "a": return 64'h3078ccccfccccc00;
      "b": return 64'hfc66667c6666fc00;
      "c": return 64'h3c66c0c0c0663c00;
      "d": return 64'hf86c6666666cf800;
      "e": return 64'hfe6268786862fe00;
      "f": return 64'hfe6268786860f000;
      "g": return 64'h3c66c0c0ce663e00;
      "h": return 64'hccccccfccccccc00;
      "i": return 64'h7830303030307800;
      "j": return 64'h1e0c0c0ccccc7800;
      "k": return 64'he6666c786c66e600;
      "l": return 64'hf06060606266fe00;
      "m": return 64'hc6eefefed6666600;
      "n": return 64'hc6e6f6decec6c600;
      "o": return 64'h386cc6c6c66c3800;
      "p": return 64'hfc66667c6060f000;
      "q": return 64'h78ccccccdc7c1c00;
      "r": return 64'hfc66667c6c66e600;
      "s": return 64'h78cce0701ccc7800;
      "t": return 64'hfcb4303030307800;
      "u": return 64'hccccccccccccfc00;
      "v": return 64'hcccccccccc783000;
      "w": return 64'hc6c6c6d6feeec600;
      "x": return 64'hc6c66c38386cc600;
      "y": return 64'hcccccc7830307800;
      "z": return 64'hfec68c183266fe00;
      "0": return 64'h7cc6cedef6e67c00;
      "1": return 64'h307030303030fc00;
      "2": return 64'h78cc0c3860ccfc00;
      "3": return 64'h78cc0c380ccc7800;
      "4": return 64'h1c3c6cccfe0c1e00;
      "5": return 64'hfcc0f80c0ccc7800;
      "6": return 64'h3860c0fccccc7100;
      "7": return 64'hfccc0c1830303000;
      "8": return 64'h78cccc78cccc7800;
      "9": return 64'h78cccc7c0c187000;
      "(": return 64'h1830606060301800;
      ")": return 64'h6030181818306000;
      "%": return 64'h00c6cc183066c600;
      "_": return 64'h00000000000000ff;
      "-": return 64'h000000fc00000000;
      ".": return 64'h0000000000c0c000;
      default: return 64'h0;
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] nibble_colour(input logic [CHAN_W-1:0] r,
                                                       input logic [CHAN_W-1:0] g,
                                                       input logic [CHAN_W-1:0] b);
    logic [VALUE_W-1:0] word;
    word = '0;
    word[23:20] = r[3:0];
    word[15:12] = g[3:0];
    word[7:4]   = b[3:0];
    return word;
  endfunction

  function automatic item_t make_char(input logic [7:0] code, input int x, input int y,
                                      input logic [23:0] fg, input logic [23:0] bg);
    item_t ch;
    ch.char_code = code[CODE_W-1:0];
    ch.origin_x  = ORGX_W'(x);
    ch.origin_y  = ORGY_W'(y);
    {ch.fg_red, ch.fg_green, ch.fg_blue} = fg;
    {ch.bg_red, ch.bg_green, ch.bg_blue} = bg;
    return ch;
  endfunction

  function automatic item_t random_char();
    logic [7:0] code;
    if ($urandom_range(0, 3) != 0) code = FONT_CHARS[$urandom_range(0, FONT_CHARS.len() - 1)];
    else code = 8'($urandom_range(0, 127));
    return make_char(code, $urandom_range(0, ORGX_MAX), $urandom_range(0, ORGY_MAX),
                     24'($urandom), 24'($urandom));
  endfunction

  task automatic predict_glyph(input item_t ch);
    logic [63:0]        bits;
    logic [VALUE_W-1:0] fg_word;
    logic [VALUE_W-1:0] bg_word;
    int                 addr;
    pixel_t             px;
    bits    = glyph_for(ch.char_code);
    fg_word = nibble_colour(ch.fg_red, ch.fg_green, ch.fg_blue);
    bg_word = nibble_colour(ch.bg_red, ch.bg_green, ch.bg_blue);
    if (bits == 64'h0) blank_chars++;
    for (int k = 0; k < 64; k++) begin
      addr = ((int'(ch.origin_y) + k / 8) * ROW_STRIDE + int'(ch.origin_x) + k % 8)
             % BUFFER_WORDS;
      px.pixel_address = ADDR_W'(addr);
      px.is_foreground = bits[63 - k];
      px.pixel_rgb     = bits[63 - k] ? fg_word : bg_word;
      px.last_pixel    = (k == 63);
      expected_pixels.push_back(px);
    end
  endtask

  task automatic send_char(input item_t ch);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    item  <= ch;
    do @(posedge clk); while (busy);
    predict_glyph(ch);
    chars_sent++;
  endtask

  task automatic report_field(input string field, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected write beat, expected none actual %h", $time, pixel);
      end else begin
        want = expected_pixels.pop_front();
        report_field("pixel_address", 32'(want.pixel_address), 32'(pixel.pixel_address));
        report_field("pixel_rgb", 32'(want.pixel_rgb), 32'(pixel.pixel_rgb));
        report_field("is_foreground", 32'(want.is_foreground), 32'(pixel.is_foreground));
        report_field("last_pixel", 32'(want.last_pixel), 32'(pixel.last_pixel));
        pixels_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_glyph_extremes();
    send_char(make_char("a", 0, 0, 24'hffffff, 24'h000000));
    send_char(make_char("_", 5, 9, 24'h0f0f0f, 24'hf0f0f0));
    send_char(make_char("0", 100, 200, 24'h123456, 24'habcdef));
    send_char(make_char("%", 333, 777, 24'hf00f0f, 24'h0ff0f0));
    send_char(make_char("(", 512, 1024, 24'h000000, 24'hffffff));
    send_char(make_char(")", 7, 3, 24'h5a5a5a, 24'ha5a5a5));
    send_char(make_char("-", 64, 64, 24'h010203, 24'h0e0d0c));
    send_char(make_char(".", 900, 1500, 24'h8f8f8f, 24'h717171));
    send_char(make_char("z", 1, 1, 24'h0c0b0a, 24'h030405));
    send_char(make_char("9", 640, 480, 24'hff00ff, 24'h00ff00));
  endtask

  task automatic test_blank_codes();
    send_char(make_char(8'h00, 10, 20, 24'hffffff, 24'h123456));
    send_char(make_char(8'h7f, 30, 40, 24'hffffff, 24'h0a0b0c));
    send_char(make_char("|", 50, 60, 24'hffffff, 24'hfedcba));
    send_char(make_char("A", 70, 80, 24'hffffff, 24'h070809));
    send_char(make_char(" ", 90, 99, 24'hffffff, 24'h0f0f0f));
  endtask

  task automatic test_address_wrap();
    send_char(make_char("m", ORGX_MAX, 0, 24'h0f0000, 24'h000f00));
    send_char(make_char("w", 0, ORGY_MAX, 24'h00000f, 24'h0f0f00));
    send_char(make_char("8", ORGX_MAX, ORGY_MAX, 24'hffffff, 24'h000000));
    send_char(make_char("_", ORGX_MAX - 7, ORGY_MAX - 7, 24'h0a0a0a, 24'h050505));
  endtask

  task automatic test_random_chars(input int count);
    gaps_on = 1'b1;
    repeat (count) send_char(random_char());
  endtask

  task automatic test_back_to_back(input int count);
    gaps_on = 1'b0;
    repeat (count) send_char(random_char());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_glyph_extremes();
    test_blank_codes();
    test_address_wrap();
    test_random_chars(160);
    test_back_to_back(40);
    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Drew %0d characters (%0d blank), checked %0d write beats, %0d mismatches.",
             chars_sent, blank_chars, pixels_checked, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
